### design/swm_pkg.sv
`timescale 1ns / 1ps
// Shared constants, control struct and a helper for the sliding window median core.
// No dependencies; imported by the sorter row and the top level.
package swm_pkg;

  localparam int WINDOW_MAX_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 32;
  localparam int CFG_W           = 7;
  localparam int WIN_SIZE_RESET  = 3;
  localparam int IN_DATA_W       = 32;
  localparam int IN_USER_W       = 1;
  localparam int OUT_DATA_W      = 40;

  typedef struct packed {
    logic load;
    logic pick;
    logic full;
  } swm_ctrl_t;

  function automatic int slot_bits(input int depth);
    int b;
    b = (depth > 1) ? $clog2(depth) : 1;
    return b;
  endfunction

endpackage

### design/sliding_window_median_core.sv
`timescale 1ns / 1ps
// Sliding window median core: top level with sequencer, ring memory and output register.
// Depends on swm_pkg, swm_ram and swm_sorter.
//
// Usage:
//   Samples enter on the s_axis channel (tdata: sample; tuser: restart). A restart
//   transaction empties the window before its sample is taken in. Results leave on
//   the m_axis channel as twice the window median (sum of the two middle entries for
//   an even window), signed, in the low SAMPLE_BITS+1 bits of tdata.
//   No result is produced until the window holds window_size samples.
//   cfg_we/cfg_wdata set window_size (0 acts as 1, above WINDOW_MAX saturates) and
//   empty the window. Write it only while the core is idle.
// Timing:
//   An input transaction steps through a ring memory read of the oldest sample and an
//   update of the sorted cell row; when it gives a result, it goes on to pick the
//   middle entries and to load the output, which raises m_axis_tvalid. The output
//   register holds a result until taken; the next sample is accepted meanwhile, and
//   the core waits in its last step only if a second result is ready before the
//   first is taken.
// Reset: window_size returns to 3, the window empties, no result pending.
module sliding_window_median_core #(
  parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [swm_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // [31:0] sample
  input  logic [swm_pkg::IN_USER_W-1:0]   s_axis_tuser,  // [0] restart
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [swm_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // [32:0] median_doubled
  input  logic                            cfg_we,
  input  logic [swm_pkg::CFG_W-1:0]       cfg_wdata
);

  import swm_pkg::*;

  localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
  localparam int SLOT_W = slot_bits(WINDOW_MAX);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_PICK,
    ST_EMIT
  } state_t;

  state_t                 state;
  logic [CNT_W-1:0]       eff_k;
  logic [SLOT_W-1:0]      lo_idx;
  logic [SLOT_W-1:0]      hi_idx;
  logic [CNT_W-1:0]       fill_count;
  logic [SLOT_W-1:0]      oldest_slot;
  logic [SAMPLE_BITS-1:0] sample;
  logic [OUT_DATA_W-1:0]  out_data;
  logic                   out_valid;

  logic                   in_fire;
  logic                   emit_go;
  logic                   restart;
  logic [SLOT_W-1:0]      rd_addr;
  logic [SAMPLE_BITS-1:0] rem_val;
  logic [SAMPLE_BITS-1:0] lo_val;
  logic [SAMPLE_BITS-1:0] hi_val;
  logic [SAMPLE_BITS:0]   sum;
  logic                   full;
  logic [CNT_W-1:0]       fill_count_next;
  logic [CNT_W-1:0]       slot_inc;
  logic [SLOT_W-1:0]      oldest_slot_next;
  logic [CNT_W-1:0]       cfg_k;
  logic [CNT_W-1:0]       cfg_mid;
  logic [SLOT_W-1:0]      cfg_lo;
  logic [SLOT_W-1:0]      cfg_hi;
  swm_ctrl_t              ctrl;

  function automatic logic [CNT_W-1:0] eff_size(input logic [CFG_W-1:0] w);
    logic [CNT_W-1:0] k;
    if (w == '0) begin
      k = CNT_W'(1);
    end else if (int'(w) > WINDOW_MAX) begin
      k = CNT_W'(WINDOW_MAX);
    end else begin
      k = CNT_W'(w);
    end
    return k;
  endfunction

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign emit_go = (state == ST_EMIT) && (!out_valid || m_axis_tready);
  assign restart = s_axis_tuser[0];
  assign rd_addr = restart ? '0 : oldest_slot;

  assign full             = (fill_count == eff_k);
  assign fill_count_next  = full ? fill_count : fill_count + CNT_W'(1);
  assign slot_inc         = CNT_W'(oldest_slot) + CNT_W'(1);
  assign oldest_slot_next = (slot_inc == eff_k) ? '0 : SLOT_W'(slot_inc);

  assign cfg_k   = eff_size(cfg_wdata);
  assign cfg_mid = cfg_k >> 1;
  assign cfg_hi  = SLOT_W'(cfg_mid);
  assign cfg_lo  = cfg_k[0] ? SLOT_W'(cfg_mid) : SLOT_W'(cfg_mid - CNT_W'(1));

  assign sum = {lo_val[SAMPLE_BITS-1], lo_val} + {hi_val[SAMPLE_BITS-1], hi_val};

  assign ctrl.load = (state == ST_UPDATE);
  assign ctrl.pick = (state == ST_PICK);
  assign ctrl.full = full;

  swm_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk   (clk),
    .we    (state == ST_UPDATE),
    .waddr (oldest_slot),
    .wdata (sample),
    .re    (in_fire),
    .raddr (rd_addr),
    .rdata (rem_val)
  );

  swm_sorter #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_sorter (
    .clk     (clk),
    .ctrl    (ctrl),
    .fill    (fill_count),
    .new_val (sample),
    .new_tag (oldest_slot),
    .rem_val (rem_val),
    .lo_idx  (lo_idx),
    .hi_idx  (hi_idx),
    .lo_val  (lo_val),
    .hi_val  (hi_val)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      eff_k       <= eff_size(CFG_W'(WIN_SIZE_RESET));
      lo_idx      <= SLOT_W'(eff_size(CFG_W'(WIN_SIZE_RESET)) >> 1);
      hi_idx      <= SLOT_W'(eff_size(CFG_W'(WIN_SIZE_RESET)) >> 1);
      fill_count  <= '0;
      oldest_slot <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (emit_go) begin
        out_data  <= OUT_DATA_W'(sum);
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            sample <= s_axis_tdata[SAMPLE_BITS-1:0];
            state  <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          state <= (fill_count_next == eff_k) ? ST_PICK : ST_IDLE;
        end
        ST_PICK: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_go) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (cfg_we) begin
        eff_k       <= cfg_k;
        lo_idx      <= cfg_lo;
        hi_idx      <= cfg_hi;
        fill_count  <= '0;
        oldest_slot <= '0;
      end else if (state == ST_UPDATE) begin
        fill_count  <= fill_count_next;
        oldest_slot <= oldest_slot_next;
      end else if (in_fire && restart) begin
        fill_count  <= '0;
        oldest_slot <= '0;
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= eff_k)
    else $error("fill count beyond window size");

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    CNT_W'(oldest_slot) < eff_k)
    else $error("ring slot beyond window size");

  a_mid_order: assert property (@(posedge clk) disable iff (rst)
    (lo_idx <= hi_idx) && (CNT_W'(hi_idx) < eff_k) && (hi_idx - lo_idx <= SLOT_W'(1)))
    else $error("middle indexes inconsistent with window size");

  a_cfg_empties: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> (fill_count == '0) && (oldest_slot == '0) && (eff_k != '0))
    else $error("register write did not empty the window");

endmodule

### design/swm_ram.sv
`timescale 1ns / 1ps
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module swm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/swm_cell.sv
`timescale 1ns / 1ps
// One cell of the sorted window row: holds one sample and its ring slot tag.
// No dependencies; instantiated by swm_sorter.
module swm_cell #(
  parameter int DATA_W = 32,
  parameter int TAG_W  = 6
) (
  input  logic              clk,
  input  logic              load,
  input  logic              full,
  input  logic              valid,
  input  logic [DATA_W-1:0] new_val,
  input  logic [TAG_W-1:0]  new_tag,
  input  logic [DATA_W-1:0] rem_val,
  input  logic [DATA_W-1:0] r_val,
  input  logic [TAG_W-1:0]  r_tag,
  input  logic              r_gr,
  input  logic [DATA_W-1:0] l_val,
  input  logic [TAG_W-1:0]  l_tag,
  input  logic              l_gtp,
  output logic [DATA_W-1:0] val_o,
  output logic [TAG_W-1:0]  tag_o,
  output logic              gr_o,
  output logic [DATA_W-1:0] shv_o,
  output logic [TAG_W-1:0]  sht_o,
  output logic              gtp_o
);

  logic [DATA_W-1:0] val;
  logic [TAG_W-1:0]  tag;
  logic              gt_new;
  logic              ge_rem;
  logic              rm;

  assign gt_new = ($signed(val) > $signed(new_val)) || ((val == new_val) && (tag > new_tag));
  assign ge_rem = ($signed(val) > $signed(rem_val)) || ((val == rem_val) && (tag >= new_tag));
  assign rm     = full && valid && ge_rem;

  assign gr_o  = !valid || gt_new;
  assign shv_o = rm ? r_val : val;
  assign sht_o = rm ? r_tag : tag;
  assign gtp_o = rm ? r_gr : gr_o;
  assign val_o = val;
  assign tag_o = tag;

  always_ff @(posedge clk) begin
    if (load) begin
      if (l_gtp) begin
        val <= l_val;
        tag <= l_tag;
      end else if (gtp_o) begin
        val <= new_val;
        tag <= new_tag;
      end else begin
        val <= shv_o;
        tag <= sht_o;
      end
    end
  end

endmodule

### design/swm_sorter.sv
`timescale 1ns / 1ps
// Row of sorted window cells plus the middle-entry pick registers.
// Depends on swm_pkg and swm_cell.
module swm_sorter #(
  parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                       clk,
  input  swm_pkg::swm_ctrl_t                         ctrl,
  input  logic [$clog2(WINDOW_MAX+1)-1:0]            fill,
  input  logic [SAMPLE_BITS-1:0]                     new_val,
  input  logic [swm_pkg::slot_bits(WINDOW_MAX)-1:0]  new_tag,
  input  logic [SAMPLE_BITS-1:0]                     rem_val,
  input  logic [swm_pkg::slot_bits(WINDOW_MAX)-1:0]  lo_idx,
  input  logic [swm_pkg::slot_bits(WINDOW_MAX)-1:0]  hi_idx,
  output logic [SAMPLE_BITS-1:0]                     lo_val,
  output logic [SAMPLE_BITS-1:0]                     hi_val
);

  import swm_pkg::*;

  localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
  localparam int SLOT_W = slot_bits(WINDOW_MAX);

  logic [SAMPLE_BITS-1:0] val_w [WINDOW_MAX];
  logic [SLOT_W-1:0]      tag_w [WINDOW_MAX];
  logic                   gr_w  [WINDOW_MAX];
  logic [SAMPLE_BITS-1:0] shv_w [WINDOW_MAX];
  logic [SLOT_W-1:0]      sht_w [WINDOW_MAX];
  logic                   gtp_w [WINDOW_MAX];
  logic [SAMPLE_BITS-1:0] lo_mux;
  logic [SAMPLE_BITS-1:0] hi_mux;

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic [SAMPLE_BITS-1:0] rv;
    logic [SLOT_W-1:0]      rt;
    logic                   rg;
    logic [SAMPLE_BITS-1:0] lv;
    logic [SLOT_W-1:0]      lt;
    logic                   lg;

    if (i == WINDOW_MAX - 1) begin : g_last
      assign rv = '0;
      assign rt = '0;
      assign rg = 1'b1;
    end else begin : g_mid
      assign rv = val_w[i+1];
      assign rt = tag_w[i+1];
      assign rg = gr_w[i+1];
    end

    if (i == 0) begin : g_first
      assign lv = '0;
      assign lt = '0;
      assign lg = 1'b0;
    end else begin : g_inner
      assign lv = shv_w[i-1];
      assign lt = sht_w[i-1];
      assign lg = gtp_w[i-1];
    end

    swm_cell #(
      .DATA_W (SAMPLE_BITS),
      .TAG_W  (SLOT_W)
    ) u_cell (
      .clk     (clk),
      .load    (ctrl.load),
      .full    (ctrl.full),
      .valid   (CNT_W'(i) < fill),
      .new_val (new_val),
      .new_tag (new_tag),
      .rem_val (rem_val),
      .r_val   (rv),
      .r_tag   (rt),
      .r_gr    (rg),
      .l_val   (lv),
      .l_tag   (lt),
      .l_gtp   (lg),
      .val_o   (val_w[i]),
      .tag_o   (tag_w[i]),
      .gr_o    (gr_w[i]),
      .shv_o   (shv_w[i]),
      .sht_o   (sht_w[i]),
      .gtp_o   (gtp_w[i])
    );
  end

  always_comb begin
    lo_mux = '0;
    hi_mux = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      if (SLOT_W'(i) == lo_idx) begin
        lo_mux = lo_mux | val_w[i];
      end
      if (SLOT_W'(i) == hi_idx) begin
        hi_mux = hi_mux | val_w[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.pick) begin
      lo_val <= lo_mux;
      hi_val <= hi_mux;
    end
  end

endmodule

### test/tb_sliding_window_median_core.sv
`timescale 1ns / 1ps
// Testbench for sliding_window_median_core: directed table, then random phases of window sizes.
// Depends on swm_pkg; predicts each median with its own ring and sorted copy of the window.
module tb_sliding_window_median_core;
  import swm_pkg::*;

  typedef logic signed [31:0] sample_t;
  typedef logic signed [32:0] median_t;
  typedef enum logic {ROW_SAMPLE, ROW_WINDOW} row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    logic [31:0] value;
    logic restart;
    logic typed;
    logic [32:0] median;
  } plan_row_t;

  localparam int ITEMS = 1800;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [31:0] SMAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SMIN = 32'h8000_0000;
  localparam logic [32:0] TWICE_MAX = 33'h0_FFFF_FFFE;
  localparam logic [32:0] TWICE_MIN = 33'h1_0000_0000;
  localparam logic [32:0] MINUS_TWO = 33'h1_FFFF_FFFE;
  localparam logic [32:0] MINUS_ONE = 33'h1_FFFF_FFFF;
  localparam int FIXED_SIZES [8] = '{64, 127, 0, 1, 2, 3, 63, 65};

  localparam plan_row_t PLAN [25] = '{
    '{ROW_SAMPLE, SMAX, 1'b0, 1'b0, 33'h0},
    '{ROW_SAMPLE, SMAX, 1'b0, 1'b0, 33'h0},
    '{ROW_SAMPLE, SMAX, 1'b0, 1'b1, TWICE_MAX},
    '{ROW_SAMPLE, SMIN, 1'b0, 1'b1, TWICE_MAX},
    '{ROW_SAMPLE, SMIN, 1'b0, 1'b1, TWICE_MIN},
    '{ROW_SAMPLE, SMIN, 1'b0, 1'b1, TWICE_MIN},
    '{ROW_SAMPLE, 32'd0, 1'b1, 1'b0, 33'h0},
    '{ROW_SAMPLE, 32'd5, 1'b0, 1'b0, 33'h0},
    '{ROW_SAMPLE, 32'hFFFF_FFF9, 1'b0, 1'b0, 33'h0},
    '{ROW_SAMPLE, 32'd5, 1'b0, 1'b0, 33'h0},
    '{ROW_SAMPLE, 32'd5, 1'b0, 1'b0, 33'h0},
    '{ROW_WINDOW, 32'd0, 1'b0, 1'b0, 33'h0},
    '{ROW_SAMPLE, SMAX, 1'b0, 1'b1, TWICE_MAX},
    '{ROW_SAMPLE, SMIN, 1'b0, 1'b1, TWICE_MIN},
    '{ROW_SAMPLE, 32'hFFFF_FFFF, 1'b1, 1'b1, MINUS_TWO},
    '{ROW_WINDOW, 32'd2, 1'b0, 1'b0, 33'h0},
    '{ROW_SAMPLE, SMAX, 1'b0, 1'b0, 33'h0},
    '{ROW_SAMPLE, SMIN, 1'b0, 1'b1, MINUS_ONE},
    '{ROW_SAMPLE, 32'h5555_5555, 1'b0, 1'b0, 33'h0},
    '{ROW_SAMPLE, 32'hAAAA_AAAA, 1'b0, 1'b0, 33'h0},
    '{ROW_WINDOW, 32'd4, 1'b0, 1'b0, 33'h0},
    '{ROW_SAMPLE, 32'd3, 1'b0, 1'b0, 33'h0},
    '{ROW_SAMPLE, 32'hFFFF_FFFD, 1'b0, 1'b0, 33'h0},
    '{ROW_SAMPLE, 32'd8, 1'b0, 1'b0, 33'h0},
    '{ROW_SAMPLE, 32'hFFFF_FFF8, 1'b0, 1'b0, 33'h0}
  };

  logic clk = 1'b0;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata;
  logic [IN_USER_W-1:0] s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b1;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  logic [CFG_W-1:0] window_reg;
  sample_t ring [WINDOW_MAX_DEF];
  sample_t ordered [WINDOW_MAX_DEF];
  int fill;
  int oldest;

  median_t medians_due [$];
  median_t want;
  int bad_medians = 0;
  int stall_cycles = 0;
  int hold_left = 0;
  bit calm = 1'b0;
  bit quiet = 1'b0;

  sliding_window_median_core dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int active_size(input logic [CFG_W-1:0] reg_val);
    int k;
    k = reg_val;
    if (k == 0) k = 1;
    if (k > WINDOW_MAX_DEF) k = WINDOW_MAX_DEF;
    return k;
  endfunction

  function automatic bit window_median(input sample_t s, input bit rs, output median_t med);
    int k;
    int j;
    sample_t leaving;
    k = active_size(window_reg);
    med = '0;
    if (rs) begin
      fill = 0;
      oldest = 0;
    end
    if (fill > k) fill = 0;
    if (oldest >= k) oldest = 0;
    if (fill == k) begin
      leaving = ring[oldest];
      j = 0;
      while (j < fill && ordered[j] != leaving) j++;
      if (j >= fill) j = fill - 1;
      while (j + 1 < fill) begin
        ordered[j] = ordered[j + 1];
        j++;
      end
      fill--;
    end
    ring[oldest] = s;
    j = fill;
    while (j > 0 && ordered[j - 1] > s) begin
      ordered[j] = ordered[j - 1];
      j--;
    end
    ordered[j] = s;
    fill++;
    oldest = (oldest + 1) % k;
    if (fill < k) return 1'b0;
    if (k % 2 == 1)
      med = {ordered[k / 2], 1'b0};
    else
      med = {ordered[k / 2 - 1][31], ordered[k / 2 - 1]} + {ordered[k / 2][31], ordered[k / 2]};
    return 1'b1;
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: s = $urandom;
      4, 5, 6: s = $signed($urandom_range(0, 8)) - 4;
      7: begin
        case ($urandom_range(0, 3))
          0: s = SMAX;
          1: s = SMIN;
          2: s = '0;
          default: s = '1;
        endcase
      end
      default: s = $signed($urandom_range(0, 2000)) - 1000;
    endcase
    return s;
  endfunction

  task automatic hold_until_drained();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (medians_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_window(input logic [CFG_W-1:0] size_val);
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = size_val;
    @(negedge clk);
    cfg_we = 1'b0;
    window_reg = size_val;
    fill = 0;
    oldest = 0;
  endtask

  task automatic send_sample(input sample_t s, input bit rs, input bit typed, input median_t typed_med);
    median_t med;
    bit has_med;
    @(negedge clk);
    if (!calm && !quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    s_axis_tdata = s;
    s_axis_tuser = rs;
    s_axis_tvalid = 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    has_med = window_median(s, rs, med);
    if (typed)
      medians_due = {medians_due, typed_med};
    else if (has_med)
      medians_due = {medians_due, med};
  endtask

  // receiver: random back-pressure bursts, always ready in calm or quiet phases
  always @(negedge clk) begin
    if (calm || quiet) begin
      m_axis_tready = 1'b1;
      hold_left = 0;
    end else if (hold_left > 0) begin
      m_axis_tready = 1'b0;
      hold_left--;
    end else if ($urandom_range(0, 5) == 0) begin
      m_axis_tready = 1'b0;
      hold_left = $urandom_range(0, 4);
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (medians_due.size() == 0) begin
          bad_medians++;
          if (bad_medians <= 10)
            $display("unexpected median: got %0d", $signed(m_axis_tdata[32:0]));
        end else begin
          want = medians_due.pop_front();
          if (m_axis_tdata[32:0] !== want) begin
            bad_medians++;
            if (bad_medians <= 10)
              $display("median mismatch: expected %0d, got %0d", want,
                       $signed(m_axis_tdata[32:0]));
          end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("simulation failed");
          $finish;
        end
      end
    end
  end

  initial begin
    int sent;
    int phase;
    int k;
    int n;
    logic [CFG_W-1:0] size_val;
    sent = 0;
    phase = 0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    window_reg = CFG_W'(WIN_SIZE_RESET);
    fill = 0;
    oldest = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (PLAN[i]) begin
      if (PLAN[i].kind == ROW_WINDOW)
        set_window(PLAN[i].value[CFG_W-1:0]);
      else
        send_sample(PLAN[i].value, PLAN[i].restart, PLAN[i].typed, PLAN[i].median);
    end

    while (sent < ITEMS) begin
      if (phase < 8)
        size_val = CFG_W'(FIXED_SIZES[phase]);
      else if ($urandom_range(0, 9) == 0)
        size_val = CFG_W'($urandom_range(0, 127));
      else
        size_val = CFG_W'($urandom_range(1, 12));
      set_window(size_val);
      calm = (phase % 4 == 3);
      k = active_size(size_val);
      n = 2 * k + $urandom_range(20, 80);
      for (int i = 0; i < n; i++) begin
        if (phase % 5 == 2 && i == n / 2) hold_until_drained();
        quiet = (sent >= ITEMS - 200);
        send_sample(random_sample(), $urandom_range(0, 39) == 0, 1'b0, '0);
        sent++;
      end
      phase++;
    end

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (bad_medians == 0 && medians_due.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
